// ----- rtl/core/percent_utf8_path_decoder_top_macros.svh -----
// assertion macros used by the path decoder queue
`ifndef PERCENT_UTF8_PATH_DECODER_TOP_MACROS_SVH
`define PERCENT_UTF8_PATH_DECODER_TOP_MACROS_SVH

// clocked check, off while reset is held
`define PUD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds during reset
`define PUD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/pud_pkg.sv -----
// types, codes and helpers for the percent/utf-8 path decoder
`timescale 1ns / 1ps
package pud_pkg;

    localparam int UNIT_W = 21;

    typedef enum logic [1:0] {
        ESC_NONE   = 2'd0,
        ESC_FIRST  = 2'd1,
        ESC_SECOND = 2'd2
    } esc_phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_HEX     = 3'd1,
        ST_TRUNC_ESC   = 3'd2,
        ST_BAD_LEAD    = 3'd3,
        ST_BAD_CONT    = 3'd4,
        ST_SURROGATE   = 3'd5,
        ST_UNTERMINATED = 3'd6,
        ST_EMPTY       = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        ENT_UNIT = 2'd0,
        ENT_PAIR = 2'd1,
        ENT_DONE = 2'd2
    } ent_kind_t;

    // one queued request: a unit, a unit to split into a surrogate pair, or an end report
    typedef struct packed {
        ent_kind_t           kind;
        logic [UNIT_W-1:0]   unit;
        status_t             status;
    } entry_t;

    localparam logic [UNIT_W-1:0] CHAR_PERCENT = 21'h25;
    localparam logic [UNIT_W-1:0] SUPP_BASE    = 21'h10000;
    localparam logic [UNIT_W-1:0] SURR_LO      = 21'hD800;
    localparam logic [UNIT_W-1:0] SURR_END     = 21'hE000;
    localparam logic [UNIT_W-1:0] HIGH_BASE    = 21'hD800;
    localparam logic [UNIT_W-1:0] LOW_BASE     = 21'hDC00;

    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD_END  = 8'hF8;

    // {valid, value} of an ascii hex digit
    function automatic logic [4:0] hex_decode(input logic [UNIT_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 21'h30 && c <= 21'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pud_queue.sv -----
// short request queue between the classifier and the output stage
`timescale 1ns / 1ps
`include "percent_utf8_path_decoder_top_macros.svh"
module pud_queue
    import pud_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    `PUD_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
    `PUD_ASSERT(a_no_pop_empty, pop |-> not_empty, "pop from empty queue")
    `PUD_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "queue count past depth")

endmodule

// ----- rtl/core/pud_front.sv -----
// input side: escape and utf-8 tracking, turns each character into queue requests
`timescale 1ns / 1ps
module pud_front
    import pud_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wide_units_32,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [UNIT_W-1:0] code_unit,
    input  logic              path_end,
    input  logic              q_full,
    output logic              push,
    output entry_t            push_entry
);

    esc_phase_t        esc_reg, esc_next;
    logic [3:0]        nib_reg, nib_next;
    logic [UNIT_W-1:0] acc_reg, acc_next;
    logic [1:0]        cont_reg, cont_next;
    status_t           err_reg, err_next;
    logic              seen_reg, seen_next;

    logic              accept;
    logic [4:0]        hex;
    logic [7:0]        byte_val;
    logic [UNIT_W-1:0] acc_shift;

    // decisions handed from the state block to the request block
    logic              emit_req;
    logic              emit_point;
    logic [UNIT_W-1:0] emit_val;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign hex       = hex_decode(code_unit);
    assign byte_val  = {nib_reg, hex[3:0]};
    assign acc_shift = {acc_reg[UNIT_W-7:0], byte_val[5:0]};

    // next state
    always_comb begin
        esc_next   = esc_reg;
        nib_next   = nib_reg;
        acc_next   = acc_reg;
        cont_next  = cont_reg;
        err_next   = err_reg;
        seen_next  = seen_reg;
        emit_req   = 1'b0;
        emit_point = 1'b0;
        emit_val   = '0;
        if (accept) begin
            if (path_end) begin
                esc_next  = ESC_NONE;
                nib_next  = '0;
                acc_next  = '0;
                cont_next = '0;
                err_next  = ST_OK;
                seen_next = 1'b0;
            end else begin
                seen_next = 1'b1;
                if (err_reg == ST_OK) begin
                    case (esc_reg)
                        ESC_FIRST: begin
                            if (!hex[4]) begin
                                err_next = ST_BAD_HEX;
                            end else begin
                                nib_next = hex[3:0];
                                esc_next = ESC_SECOND;
                            end
                        end
                        ESC_SECOND: begin
                            if (!hex[4]) begin
                                err_next = ST_BAD_HEX;
                            end else begin
                                esc_next = ESC_NONE;
                                if (cont_reg != 2'd0) begin
                                    if (byte_val[7:6] != 2'b10) begin
                                        err_next = ST_BAD_CONT;
                                    end else begin
                                        acc_next  = acc_shift;
                                        cont_next = cont_reg - 2'd1;
                                        if (cont_reg == 2'd1) begin
                                            if (acc_shift >= SURR_LO && acc_shift < SURR_END) begin
                                                err_next = ST_SURROGATE;
                                            end else begin
                                                emit_req   = 1'b1;
                                                emit_point = 1'b1;
                                                emit_val   = acc_shift;
                                            end
                                        end
                                    end
                                end else if (!byte_val[7]) begin
                                    emit_req   = 1'b1;
                                    emit_point = 1'b1;
                                    emit_val   = {13'd0, byte_val};
                                end else if (byte_val < LEAD2_MIN) begin
                                    err_next = ST_BAD_LEAD;
                                end else if (byte_val < LEAD3_MIN) begin
                                    acc_next  = {16'd0, byte_val[4:0]};
                                    cont_next = 2'd1;
                                end else if (byte_val < LEAD4_MIN) begin
                                    acc_next  = {17'd0, byte_val[3:0]};
                                    cont_next = 2'd2;
                                end else if (byte_val < LEAD_END) begin
                                    acc_next  = {18'd0, byte_val[2:0]};
                                    cont_next = 2'd3;
                                end else begin
                                    err_next = ST_BAD_LEAD;
                                end
                            end
                        end
                        default: begin
                            if (code_unit == CHAR_PERCENT) begin
                                esc_next = ESC_FIRST;
                            end else if (cont_reg != 2'd0) begin
                                err_next = ST_BAD_CONT;
                            end else begin
                                emit_req = 1'b1;
                                emit_val = code_unit;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // requests into the queue
    always_comb begin
        push_entry = '{kind: ENT_UNIT, unit: emit_val, status: ST_OK};
        push       = 1'b0;
        if (accept && path_end) begin
            push            = 1'b1;
            push_entry.kind = ENT_DONE;
            push_entry.unit = '0;
            if (err_reg != ST_OK) begin
                push_entry.status = err_reg;
            end else if (esc_reg != ESC_NONE) begin
                push_entry.status = ST_TRUNC_ESC;
            end else if (cont_reg != 2'd0) begin
                push_entry.status = ST_UNTERMINATED;
            end else if (!seen_reg) begin
                push_entry.status = ST_EMPTY;
            end
        end else if (emit_req) begin
            push = 1'b1;
            if (emit_point && !wide_units_32 && emit_val >= SUPP_BASE) begin
                push_entry.kind = ENT_PAIR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg  <= ESC_NONE;
            nib_reg  <= '0;
            acc_reg  <= '0;
            cont_reg <= '0;
            err_reg  <= ST_OK;
            seen_reg <= 1'b0;
        end else begin
            esc_reg  <= esc_next;
            nib_reg  <= nib_next;
            acc_reg  <= acc_next;
            cont_reg <= cont_next;
            err_reg  <= err_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ----- rtl/core/pud_back.sv -----
// output side: registered result stage, splits supplementary points into surrogate pairs
`timescale 1ns / 1ps
module pud_back
    import pud_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  entry_t            q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [UNIT_W-1:0] out_unit,
    output logic              unit_valid,
    output logic              path_done,
    output status_t           status,
    output logic              last_of_run
);

    logic              valid_reg, valid_next;
    logic              half_reg, half_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic              uvalid_reg, uvalid_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic              load;
    logic [UNIT_W-1:0] supp_off;
    logic [UNIT_W-1:0] high_unit;
    logic [UNIT_W-1:0] low_unit;

    assign load      = !valid_reg || m_ready;
    assign supp_off  = q_head.unit - SUPP_BASE;
    assign high_unit = HIGH_BASE + {10'd0, supp_off[UNIT_W-1:10]};
    assign low_unit  = LOW_BASE + {11'd0, q_head.unit[9:0]};

    always_comb begin
        valid_next  = valid_reg;
        half_next   = half_reg;
        unit_next   = unit_reg;
        uvalid_next = uvalid_reg;
        done_next   = done_reg;
        status_next = status_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        if (load) begin
            valid_next = q_not_empty;
            if (q_not_empty) begin
                status_next = q_head.status;
                case (q_head.kind)
                    ENT_PAIR: begin
                        uvalid_next = 1'b1;
                        done_next   = 1'b0;
                        if (!half_reg) begin
                            // high surrogate first, keep the request for the low one
                            unit_next = high_unit;
                            last_next = 1'b0;
                            half_next = 1'b1;
                        end else begin
                            unit_next = low_unit;
                            last_next = 1'b1;
                            half_next = 1'b0;
                            q_pop     = 1'b1;
                        end
                    end
                    ENT_DONE: begin
                        unit_next   = '0;
                        uvalid_next = 1'b0;
                        done_next   = 1'b1;
                        last_next   = 1'b1;
                        q_pop       = 1'b1;
                    end
                    default: begin
                        unit_next   = q_head.unit;
                        uvalid_next = 1'b1;
                        done_next   = 1'b0;
                        last_next   = 1'b1;
                        q_pop       = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg   <= unit_next;
        uvalid_reg <= uvalid_next;
        done_reg   <= done_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_valid     = valid_reg;
    assign out_unit    = unit_reg;
    assign unit_valid  = uvalid_reg;
    assign path_done   = done_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

endmodule

// ----- rtl/core/percent_utf8_path_decoder_top.sv -----
// top level of the percent-escape / utf-8 path decoder with apb control
`timescale 1ns / 1ps
// Decodes percent-escaped UTF-8 paths streamed one character per request, closed by a
// request with tlast set. Input is taken at one request per clock: s_axis_tready only
// drops while the Q_DEPTH-entry queue between the classifier and the output stage is
// full. Results leave at one per clock from a registered output stage while m_axis_tready
// is held high; a supplementary code point in 16-bit mode leaves as two results, the high
// surrogate and then the low one, so the output stage and the queue set the sustained
// rate. Escape digits and incomplete sequences produce no result. The end request always
// produces one result carrying the path status. Register 0 (byte address 0), bit 0,
// selects full code points (1) or UTF-16 units (0); change it only while idle.
module percent_utf8_path_decoder_top
    import pud_pkg::*;
#(
    parameter int Q_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_unit, [23:21] zero
    input  logic        s_axis_tlast,   // path_end
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] out_unit, [23:21] status
    output logic [1:0]  m_axis_tuser,   // [0] unit_valid, [1] path_done
    output logic        m_axis_tlast    // last_of_run
);

    logic              wide_reg, wide_next;
    logic              cfg_wr;

    logic              q_full;
    logic              q_push;
    entry_t            q_push_entry;
    logic              q_pop;
    entry_t            q_head;
    logic              q_not_empty;

    logic [UNIT_W-1:0] out_unit;
    logic              unit_valid;
    logic              path_done;
    status_t           status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {31'd0, wide_reg};

    always_comb begin
        wide_next = wide_reg;
        if (cfg_wr) begin
            wide_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg <= 1'b0;
        end else begin
            wide_reg <= wide_next;
        end
    end

    pud_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wide_units_32 (wide_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .code_unit     (s_axis_tdata[UNIT_W-1:0]),
        .path_end      (s_axis_tlast),
        .q_full        (q_full),
        .push          (q_push),
        .push_entry    (q_push_entry)
    );

    pud_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty)
    );

    pud_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .out_unit    (out_unit),
        .unit_valid  (unit_valid),
        .path_done   (path_done),
        .status      (status),
        .last_of_run (m_axis_tlast)
    );

    assign m_axis_tdata = {status, out_unit};
    assign m_axis_tuser = {path_done, unit_valid};

endmodule
